@@ design/assert_macros.svh @@
// Assertion macros for the loader RTL, included by fpl_back.
// Depends on nothing; every macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define FPL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define FPL_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

@@ design/fpl_pkg.sv @@
// Shared types and constants of the passive serial loader.
// Used by every module of the loader; depends on nothing.
package fpl_pkg;

	localparam int WORD_BITS = 32;
	localparam int BIT_W     = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
	localparam int TICK_W    = 16;
	localparam int JOB_DEPTH = 2;

	localparam logic [TICK_W-1:0] SETTLE_RESET = 16'd10;
	localparam logic [TICK_W-1:0] PULSE_RESET  = 16'd100;

	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_WORD  = 2'd2;

	localparam logic [1:0] REG_SETTLE = 2'd0;
	localparam logic [1:0] REG_PULSE  = 2'd1;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_HIGH   = 4'd1,
		PH_LOW    = 4'd2,
		PH_WFALL  = 4'd3,
		PH_WRISE  = 4'd4,
		PH_SETTLE = 4'd5,
		PH_STREAM = 4'd6,
		PH_RESET  = 4'd8
	} phase_t;

	typedef enum logic [1:0] {
		ERR_NONE       = 2'd0,
		ERR_NOT_STREAM = 2'd1,
		ERR_BUSY       = 2'd2
	} err_t;

	typedef struct packed {
		logic                 is_word;
		logic [WORD_BITS-1:0] word;
		logic                 ncfg;
		logic                 dclk;
		logic                 data0;
		logic                 reset_n;
		phase_t               phase;
		logic                 done;
		logic                 ok;
		err_t                 error;
	} job_t;

endpackage

@@ design/fpl_front.sv @@
// Front of the loader: holds the sequencer state and configuration registers,
// classifies each command and turns it into one job. Depends on fpl_pkg.
module fpl_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [1:0]                  cmd,
	input  logic [fpl_pkg::WORD_BITS-1:0] word,
	input  logic                        final_word,
	input  logic                        nstatus_in,
	input  logic                        conf_done_in,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [fpl_pkg::TICK_W-1:0]  cfg_data,
	output fpl_pkg::job_t               job
);

	fpl_pkg::phase_t               phase_q, phase_d;
	logic [fpl_pkg::TICK_W-1:0]    cnt_q, cnt_d;
	logic [fpl_pkg::TICK_W-1:0]    settle_q, pulse_q, limit;
	logic [fpl_pkg::TICK_W:0]      cnt_inc;
	logic                          hit;
	logic ncfg_q, ncfg_d, dclk_q, dclk_d, data0_q, data0_d, rst_q, rst_d;

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		ncfg_d  = ncfg_q;
		dclk_d  = dclk_q;
		data0_d = data0_q;
		rst_d   = rst_q;
		job     = '0;
		job.word  = word;
		job.error = fpl_pkg::ERR_NONE;
		limit   = (phase_q == fpl_pkg::PH_RESET) ? pulse_q : settle_q;
		cnt_inc = {1'b0, cnt_q} + {{fpl_pkg::TICK_W{1'b0}}, 1'b1};
		hit     = cnt_inc >= {1'b0, limit};
		if (cmd == fpl_pkg::CMD_START) begin
			if (phase_q != fpl_pkg::PH_IDLE) begin
				job.error = fpl_pkg::ERR_BUSY;
			end else begin
				ncfg_d  = 1'b1;
				dclk_d  = 1'b0;
				phase_d = fpl_pkg::PH_HIGH;
				cnt_d   = '0;
			end
		end else if (cmd == fpl_pkg::CMD_WORD) begin
			if (phase_q != fpl_pkg::PH_STREAM) begin
				job.error = fpl_pkg::ERR_NOT_STREAM;
			end else begin
				job.is_word = 1'b1;
				data0_d     = word[fpl_pkg::WORD_BITS-1];
				dclk_d      = 1'b0;
				if (final_word) begin
					rst_d   = 1'b0;
					phase_d = fpl_pkg::PH_RESET;
					cnt_d   = '0;
				end
			end
		end else begin
			unique case (phase_q)
				fpl_pkg::PH_HIGH, fpl_pkg::PH_LOW, fpl_pkg::PH_SETTLE,
				fpl_pkg::PH_RESET: begin
					cnt_d = hit ? '0 : cnt_inc[fpl_pkg::TICK_W-1:0];
					if (hit) begin
						unique case (phase_q)
							fpl_pkg::PH_HIGH: begin
								ncfg_d  = 1'b0;
								phase_d = fpl_pkg::PH_LOW;
							end
							fpl_pkg::PH_LOW:    phase_d = fpl_pkg::PH_WFALL;
							fpl_pkg::PH_SETTLE: phase_d = fpl_pkg::PH_STREAM;
							default: begin
								rst_d    = 1'b1;
								job.done = 1'b1;
								job.ok   = conf_done_in;
								phase_d  = fpl_pkg::PH_IDLE;
							end
						endcase
					end
				end
				fpl_pkg::PH_WFALL: begin
					if (!nstatus_in) begin
						ncfg_d  = 1'b1;
						phase_d = fpl_pkg::PH_WRISE;
					end
				end
				fpl_pkg::PH_WRISE: begin
					if (nstatus_in) begin
						phase_d = fpl_pkg::PH_SETTLE;
						cnt_d   = '0;
					end
				end
				default: ;
			endcase
		end
		job.ncfg    = ncfg_d;
		job.dclk    = dclk_d;
		job.data0   = data0_d;
		job.reset_n = job.is_word ? rst_q : rst_d;
		job.phase   = job.is_word ? fpl_pkg::PH_STREAM : phase_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= fpl_pkg::PH_IDLE;
			cnt_q   <= '0;
			ncfg_q  <= 1'b1;
			dclk_q  <= 1'b0;
			data0_q <= 1'b0;
			rst_q   <= 1'b1;
		end else if (accept) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			ncfg_q  <= ncfg_d;
			dclk_q  <= dclk_d;
			data0_q <= data0_d;
			rst_q   <= rst_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= fpl_pkg::SETTLE_RESET;
			pulse_q  <= fpl_pkg::PULSE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				fpl_pkg::REG_SETTLE: settle_q <= cfg_data;
				fpl_pkg::REG_PULSE:  pulse_q  <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

@@ design/fpl_job_fifo.sv @@
// Short job queue between the front and the back of the loader.
// Depends on fpl_pkg for the job type and depth.
module fpl_job_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  fpl_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output fpl_pkg::job_t head_job
);

	localparam int PTR_W = (fpl_pkg::JOB_DEPTH > 1) ? $clog2(fpl_pkg::JOB_DEPTH) : 1;
	localparam int CNT_W = $clog2(fpl_pkg::JOB_DEPTH + 1);

	fpl_pkg::job_t    mem_q [fpl_pkg::JOB_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] count_q;

	assign full       = count_q == CNT_W'(fpl_pkg::JOB_DEPTH);
	assign head_valid = count_q != '0;
	assign head_job   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(fpl_pkg::JOB_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(fpl_pkg::JOB_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

endmodule

@@ design/fpl_back.sv @@
// Back of the loader: expands queued jobs into pin-level results, one a cycle
// while pop allows, into the output register; uses fpl_pkg, assert_macros.svh.
`include "assert_macros.svh"

module fpl_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  fpl_pkg::job_t head_job,
	output logic          job_pop,
	input  logic          pop,
	output logic          empty,
	output logic          ncfg_out,
	output logic          dclk_out,
	output logic          data0_out,
	output logic          reset_n_out,
	output logic [3:0]    phase_out,
	output logic          done_res,
	output logic          cfg_ok,
	output logic [1:0]    error,
	output logic          last
);

	logic [fpl_pkg::BIT_W-1:0] bit_q;
	logic                      half_q;
	logic                      out_valid_q;
	logic                      load;
	logic                      res_last;
	logic                      res_dclk;
	logic                      res_data0;

	assign empty = !out_valid_q;
	assign load  = head_valid && (!out_valid_q || pop);

	always_comb begin
		if (head_job.is_word) begin
			res_dclk  = !half_q;
			res_data0 = head_job.word[bit_q];
			res_last  = half_q && (bit_q == fpl_pkg::BIT_W'(fpl_pkg::WORD_BITS - 1));
		end else begin
			res_dclk  = head_job.dclk;
			res_data0 = head_job.data0;
			res_last  = 1'b1;
		end
	end

	assign job_pop = load && res_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q       <= '0;
			half_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (load) begin
				if (res_last) begin
					bit_q  <= '0;
					half_q <= 1'b0;
				end else begin
					half_q <= !half_q;
					if (half_q) begin
						bit_q <= bit_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ncfg_out    <= head_job.ncfg;
			dclk_out    <= res_dclk;
			data0_out   <= res_data0;
			reset_n_out <= head_job.reset_n;
			phase_out   <= head_job.phase;
			done_res    <= head_job.done;
			cfg_ok      <= head_job.ok;
			error       <= head_job.error;
			last        <= res_last;
		end
	end

	`FPL_ASSERT(a_mid_word_has_job, (bit_q != '0 || half_q) |-> (head_valid && head_job.is_word), "word expansion lost its job")
	`FPL_NEVER(a_pop_without_load, job_pop && !load, "job released without a result")
	`FPL_ASSERT(a_result_held, (out_valid_q && !pop) |=> out_valid_q, "waiting result dropped")

endmodule

@@ design/fpga_passive_serial_loader.sv @@
// Top level of the FPGA passive serial configuration loader.
// Instantiates fpl_front, fpl_job_fifo and fpl_back; depends on fpl_pkg.
//
// Commands enter through push/full: a transfer happens when push is high and
// full is low. Results leave through empty/pop: the oldest result is on the
// result ports while empty is low and is transferred when pop is high.
// Each command is classified and the sequencer state updated in the cycle it
// is taken, and a job goes into a two-entry queue. The back end turns a
// streamed word into 64 results, one per cycle while pop is high, data with
// clock high then clock low for each bit; every other command gives one
// result. Single results sustain one command per cycle while pop is high; a
// word holds the back end for all 64 of its results, which sets the rate
// while streaming. Settle and reset-pulse lengths are written over
// cfg_valid/cfg_ready, which is always ready; the user must write them only
// while the block is idle, which the block itself does not enforce.
// Reset puts the sequencer in idle with the config line and FPGA reset high
// and the registers at 10 and 100 ticks. When the receiver holds off pop, the
// queue fills and full rises to hold back new commands.
module fpga_passive_serial_loader (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [1:0]                    cmd,
	input  logic [fpl_pkg::WORD_BITS-1:0] word,
	input  logic                          final_word,
	input  logic                          nstatus_in,
	input  logic                          conf_done_in,
	output logic                          empty,
	input  logic                          pop,
	output logic                          ncfg_out,
	output logic                          dclk_out,
	output logic                          data0_out,
	output logic                          reset_n_out,
	output logic [3:0]                    phase_out,
	output logic                          done_res,
	output logic                          cfg_ok,
	output logic [1:0]                    error,
	output logic                          last,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [fpl_pkg::TICK_W-1:0]    cfg_data
);

	fpl_pkg::job_t new_job, head_job;
	logic          accept, head_valid, job_pop;

	assign cfg_ready = 1'b1;
	assign accept    = push && !full;

	fpl_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.cmd          (cmd),
		.word         (word),
		.final_word   (final_word),
		.nstatus_in   (nstatus_in),
		.conf_done_in (conf_done_in),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.job          (new_job)
	);

	fpl_job_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.push_job   (new_job),
		.full       (full),
		.pop        (job_pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	fpl_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_job    (head_job),
		.job_pop     (job_pop),
		.pop         (pop),
		.empty       (empty),
		.ncfg_out    (ncfg_out),
		.dclk_out    (dclk_out),
		.data0_out   (data0_out),
		.reset_n_out (reset_n_out),
		.phase_out   (phase_out),
		.done_res    (done_res),
		.cfg_ok      (cfg_ok),
		.error       (error),
		.last        (last)
	);

endmodule

@@ dv/fpga_passive_serial_loader_tb.sv @@
// Self-checking testbench for the passive serial configuration loader.
// Predicts every pin-level result from its own sequencer model and checks them in order.
// Depends on fpl_pkg and fpga_passive_serial_loader.
module fpga_passive_serial_loader_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fpl_pkg::*;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct {
		logic       ncfg;
		logic       dclk;
		logic       data0;
		logic       reset_n;
		logic [3:0] phase;
		logic       done;
		logic       ok;
		logic [1:0] err;
		logic       last;
	} pin_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	logic [1:0]           cmd;
	logic [WORD_BITS-1:0] word;
	logic                 final_word;
	logic                 nstatus_in;
	logic                 conf_done_in;
	logic                 empty;
	logic                 pop;
	logic                 ncfg_out;
	logic                 dclk_out;
	logic                 data0_out;
	logic                 reset_n_out;
	logic [3:0]           phase_out;
	logic                 done_res;
	logic                 cfg_ok;
	logic [1:0]           error;
	logic                 last;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [1:0]           cfg_index;
	logic [TICK_W-1:0]    cfg_data;

	pin_result_t pin_results_due[$];

	phase_t            seq_phase;
	logic [TICK_W-1:0] seq_ticks;
	logic              lvl_ncfg;
	logic              lvl_dclk;
	logic              lvl_data0;
	logic              lvl_reset_n;
	logic [TICK_W-1:0] reg_settle;
	logic [TICK_W-1:0] reg_pulse;

	int fail_count = 0;
	int cycle_count = 0;
	int items_sent = 0;
	int burst_left = 0;
	int gap_max = 0;
	int stall_pct = 0;
	int hold_left = 0;

	fpga_passive_serial_loader dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.cmd(cmd),
		.word(word),
		.final_word(final_word),
		.nstatus_in(nstatus_in),
		.conf_done_in(conf_done_in),
		.empty(empty),
		.pop(pop),
		.ncfg_out(ncfg_out),
		.dclk_out(dclk_out),
		.data0_out(data0_out),
		.reset_n_out(reset_n_out),
		.phase_out(phase_out),
		.done_res(done_res),
		.cfg_ok(cfg_ok),
		.error(error),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic logic rand_bit();
		return 1'($urandom_range(1));
	endfunction

	function automatic void push_result(phase_t ph, logic done, logic ok, err_t e, logic lst);
		pin_result_t r;
		r.ncfg = lvl_ncfg;
		r.dclk = lvl_dclk;
		r.data0 = lvl_data0;
		r.reset_n = lvl_reset_n;
		r.phase = ph;
		r.done = done;
		r.ok = ok;
		r.err = e;
		r.last = lst;
		pin_results_due.push_back(r);
	endfunction

	// A limit of zero behaves as one.
	function automatic bit count_reached(input logic [TICK_W-1:0] lim);
		int nxt;
		nxt = seq_ticks + 1;
		if (nxt >= lim) begin
			seq_ticks = '0;
			return 1'b1;
		end
		seq_ticks = TICK_W'(nxt);
		return 1'b0;
	endfunction

	function automatic void advance_sequencer(input logic [1:0] c, input logic [WORD_BITS-1:0] w,
			input logic f, input logic nst, input logic cd);
		logic done;
		logic ok;
		case (c)
			CMD_START: begin
				if (seq_phase != PH_IDLE) begin
					push_result(seq_phase, 1'b0, 1'b0, ERR_BUSY, 1'b1);
				end else begin
					lvl_ncfg = 1'b1;
					lvl_dclk = 1'b0;
					seq_phase = PH_HIGH;
					seq_ticks = '0;
					push_result(seq_phase, 1'b0, 1'b0, ERR_NONE, 1'b1);
				end
			end
			CMD_WORD: begin
				if (seq_phase != PH_STREAM) begin
					push_result(seq_phase, 1'b0, 1'b0, ERR_NOT_STREAM, 1'b1);
				end else begin
					for (int j = 0; j < WORD_BITS; j++) begin
						lvl_data0 = w[j];
						lvl_dclk = 1'b1;
						push_result(PH_STREAM, 1'b0, 1'b0, ERR_NONE, 1'b0);
						lvl_dclk = 1'b0;
						push_result(PH_STREAM, 1'b0, 1'b0, ERR_NONE, j == WORD_BITS - 1);
					end
					if (f) begin
						lvl_reset_n = 1'b0;
						seq_phase = PH_RESET;
						seq_ticks = '0;
					end
				end
			end
			default: begin
				done = 1'b0;
				ok = 1'b0;
				case (seq_phase)
					PH_HIGH: begin
						if (count_reached(reg_settle)) begin
							lvl_ncfg = 1'b0;
							seq_phase = PH_LOW;
						end
					end
					PH_LOW: begin
						if (count_reached(reg_settle))
							seq_phase = PH_WFALL;
					end
					PH_WFALL: begin
						if (!nst) begin
							lvl_ncfg = 1'b1;
							seq_phase = PH_WRISE;
						end
					end
					PH_WRISE: begin
						if (nst) begin
							seq_phase = PH_SETTLE;
							seq_ticks = '0;
						end
					end
					PH_SETTLE: begin
						if (count_reached(reg_settle))
							seq_phase = PH_STREAM;
					end
					PH_RESET: begin
						if (count_reached(reg_pulse)) begin
							lvl_reset_n = 1'b1;
							done = 1'b1;
							ok = cd;
							seq_phase = PH_IDLE;
						end
					end
					default: begin
					end
				endcase
				push_result(seq_phase, done, ok, ERR_NONE, 1'b1);
			end
		endcase
	endfunction

	task automatic check_field(input string name, input logic [3:0] want, input logic [3:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		pin_result_t exp_r;
		if (arst_n && pop && !empty) begin
			if (pin_results_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, got phase %0h error %0h",
					$time, phase_out, error);
				fail_count++;
			end else begin
				exp_r = pin_results_due.pop_front();
				check_field("ncfg_out", 4'(exp_r.ncfg), 4'(ncfg_out));
				check_field("dclk_out", 4'(exp_r.dclk), 4'(dclk_out));
				check_field("data0_out", 4'(exp_r.data0), 4'(data0_out));
				check_field("reset_n_out", 4'(exp_r.reset_n), 4'(reset_n_out));
				check_field("phase_out", exp_r.phase, phase_out);
				check_field("done_res", 4'(exp_r.done), 4'(done_res));
				check_field("cfg_ok", 4'(exp_r.ok), 4'(cfg_ok));
				check_field("error", 4'(exp_r.err), 4'(error));
				check_field("last", 4'(exp_r.last), 4'(last));
			end
		end
	end

	// The receiver either honours a long hold-off or pops, stalling at random by stall_pct.
	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				pop = 1'b0;
				hold_left--;
			end else begin
				pop = (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic send_item(input logic [1:0] c, input logic [WORD_BITS-1:0] w, input logic f,
			input logic nst, input logic cd);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
			if (gap > 0) begin
				@(negedge clk);
				push = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		push = 1'b1;
		cmd = c;
		word = w;
		final_word = f;
		nstatus_in = nst;
		conf_done_in = cd;
		do @(posedge clk); while (full);
		advance_sequencer(c, w, f, nst, cd);
		items_sent++;
	endtask

	task automatic send_random_item();
		send_item(2'($urandom_range(3)), $urandom, rand_bit(), rand_bit(), rand_bit());
	endtask

	task automatic wait_results_drained();
		@(negedge clk);
		push = 1'b0;
		while (pin_results_due.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [TICK_W-1:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_SETTLE)
			reg_settle = val;
		else
			reg_pulse = val;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Feeds well-formed commands, or random ones at noise_pct, until the target phase.
	task automatic drive_until(input phase_t target, input int words, input int noise_pct);
		int words_left;
		words_left = words;
		while (seq_phase != target) begin
			if ($urandom_range(99) < noise_pct) begin
				send_random_item();
			end else begin
				case (seq_phase)
					PH_WFALL:
						send_item(CMD_TICK, $urandom, rand_bit(), $urandom_range(2) == 0,
							rand_bit());
					PH_WRISE:
						send_item(CMD_TICK, $urandom, rand_bit(), $urandom_range(2) != 0,
							rand_bit());
					PH_STREAM: begin
						if ($urandom_range(5) == 0) begin
							send_item(CMD_TICK, $urandom, rand_bit(), rand_bit(), rand_bit());
						end else begin
							send_item(CMD_WORD, $urandom, words_left <= 1, rand_bit(),
								rand_bit());
							words_left--;
						end
					end
					default:
						send_item(CMD_TICK, $urandom, rand_bit(), rand_bit(), rand_bit());
				endcase
			end
		end
	endtask

	task automatic run_sequence(input int words, input int noise_pct);
		send_item(CMD_START, $urandom, rand_bit(), rand_bit(), rand_bit());
		drive_until(PH_IDLE, words, noise_pct);
	endtask

	task automatic test_directed_run();
		gap_max = 0;
		stall_pct = 0;
		send_item(CMD_TICK, 32'h0, 1'b0, 1'b1, 1'b1);
		send_item(CMD_SPARE, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
		send_item(CMD_WORD, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
		send_item(CMD_START, 32'h0, 1'b0, 1'b0, 1'b0);
		send_item(CMD_START, 32'h0, 1'b0, 1'b0, 1'b0);
		send_item(CMD_WORD, 32'h1234_5678, 1'b1, 1'b0, 1'b0);
		send_item(CMD_SPARE, 32'h0, 1'b0, 1'b1, 1'b0);
		drive_until(PH_WFALL, 0, 0);
		send_item(CMD_TICK, 32'h0, 1'b0, 1'b1, 1'b0);
		send_item(CMD_TICK, 32'h0, 1'b0, 1'b0, 1'b0);
		send_item(CMD_TICK, 32'h0, 1'b0, 1'b0, 1'b0);
		send_item(CMD_TICK, 32'h0, 1'b0, 1'b1, 1'b0);
		drive_until(PH_STREAM, 0, 0);
		send_item(CMD_WORD, 32'h0000_0000, 1'b0, 1'b0, 1'b0);
		send_item(CMD_WORD, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1);
		send_item(CMD_TICK, 32'h0, 1'b1, 1'b0, 1'b1);
		send_item(CMD_START, 32'h0, 1'b0, 1'b1, 1'b0);
		send_item(CMD_WORD, 32'h5A5A_A5A5, 1'b0, 1'b1, 1'b0);
		send_item(CMD_WORD, 32'h8000_0001, 1'b1, 1'b0, 1'b1);
		send_item(CMD_WORD, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
		send_item(CMD_START, 32'h0, 1'b0, 1'b0, 1'b0);
		wait_results_drained();
		write_reg(REG_PULSE, 16'd4);
		while (seq_phase != PH_IDLE)
			send_item(CMD_TICK, 32'h0, 1'b0, 1'b1, 1'b1);
		wait_results_drained();
	endtask

	task automatic test_register_extremes();
		gap_max = 2;
		stall_pct = 30;
		write_reg(REG_SETTLE, 16'd0);
		write_reg(REG_PULSE, 16'd0);
		run_sequence(2, 0);
		wait_results_drained();
		write_reg(REG_SETTLE, 16'd1);
		write_reg(REG_PULSE, 16'd1);
		run_sequence(1, 5);
		wait_results_drained();
		gap_max = 0;
		stall_pct = 0;
		write_reg(REG_SETTLE, 16'd0);
		write_reg(REG_PULSE, 16'd2);
		run_sequence(1, 0);
		wait_results_drained();
		write_reg(REG_SETTLE, 16'd3);
		write_reg(REG_PULSE, 16'd5);
	endtask

	task automatic test_backpressure();
		gap_max = 0;
		stall_pct = 0;
		send_item(CMD_START, 32'h0, 1'b0, 1'b0, 1'b0);
		drive_until(PH_STREAM, 0, 0);
		hold_left = 300;
		send_item(CMD_WORD, $urandom, 1'b0, 1'b1, 1'b0);
		repeat (6) send_item(CMD_TICK, $urandom, 1'b0, rand_bit(), rand_bit());
		send_item(CMD_START, $urandom, 1'b1, 1'b0, 1'b1);
		send_item(CMD_WORD, $urandom, 1'b1, 1'b0, 1'b0);
		stall_pct = 50;
		drive_until(PH_IDLE, 0, 0);
		wait_results_drained();
	endtask

	task automatic test_random_runs();
		int first;
		first = items_sent;
		while (items_sent - first < 40) begin
			gap_max = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 4);
			case ($urandom_range(2))
				0: stall_pct = 0;
				1: stall_pct = 30;
				default: stall_pct = 70;
			endcase
			if ($urandom_range(9) < 8) begin
				if ($urandom_range(1) == 1) begin
					wait_results_drained();
					write_reg(REG_SETTLE, TICK_W'($urandom_range(5)));
					write_reg(REG_PULSE, TICK_W'($urandom_range(6)));
				end
				run_sequence($urandom_range(1, 3), 10);
			end else begin
				repeat ($urandom_range(1, 4)) send_random_item();
				drive_until(PH_IDLE, 1, 10);
			end
			if ($urandom_range(3) == 0)
				wait_results_drained();
		end
		wait_results_drained();
	endtask

	// Leaves the block part way through a run, so it must be the last test.
	task automatic test_longest_settle();
		gap_max = 0;
		stall_pct = 0;
		write_reg(REG_SETTLE, 16'hFFFF);
		write_reg(REG_PULSE, 16'hFFFF);
		send_item(CMD_START, 32'h0, 1'b0, 1'b1, 1'b0);
		repeat (4) send_item(CMD_TICK, $urandom, 1'b0, rand_bit(), rand_bit());
		repeat (3) send_item(CMD_TICK, $urandom, 1'b0, 1'b0, 1'b1);
		send_item(CMD_WORD, $urandom, 1'b1, 1'b0, 1'b0);
		send_item(CMD_START, $urandom, 1'b0, 1'b1, 1'b1);
		wait_results_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		cmd = CMD_TICK;
		word = '0;
		final_word = 1'b0;
		nstatus_in = 1'b0;
		conf_done_in = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_SETTLE;
		cfg_data = '0;
		reg_settle = SETTLE_RESET;
		reg_pulse = PULSE_RESET;
		seq_phase = PH_IDLE;
		seq_ticks = '0;
		lvl_ncfg = 1'b1;
		lvl_dclk = 1'b0;
		lvl_data0 = 1'b0;
		lvl_reset_n = 1'b1;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_run();
		test_register_extremes();
		test_backpressure();
		test_random_runs();
		test_longest_settle();

		wait_results_drained();
		repeat (100) @(posedge clk);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
